@@ src/npc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// npc_pkg - shared types and constants for the nibble pixel column packer
// Holds the configuration and request structs, register codes and widths
// used by the front end, the request queue, the back end and the top level.
// ----------------------------------------------------------------------------
package npc_pkg;

	// panel size defaults
	localparam int COLUMNS_DEF = 64;
	localparam int ROWS_DEF    = 64;

	// field widths
	localparam int POS_W      = 7;   // internal column / row counters
	localparam int IDX_W      = 6;   // reported column / row index
	localparam int WORD_W     = 16;  // packed column word
	localparam int NIB_W      = 4;   // one pixel
	localparam int NIBS       = 4;   // pixels per column word
	localparam int WIDTH_W    = 9;   // region width / pixels in row
	localparam int MAX_WIDTH  = 256;
	localparam int OX_W       = 8;
	localparam int OY_W       = 6;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 9;

	// request queue between front and back
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X     = 4'd0,
		CFG_ORIGIN_Y     = 4'd1,
		CFG_REGION_WIDTH = 4'd2,
		CFG_BINARY_MODE  = 4'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [OX_W-1:0]    origin_x;
		logic [OY_W-1:0]    origin_y;
		logic [WIDTH_W-1:0] region_width;
		logic               binary_mode;
	} cfg_t;

	// one column write request: position, assembled pixels, covered nibbles
	typedef struct packed {
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
		logic [WORD_W-1:0] word;
		logic [NIBS-1:0]   cov;   // bit i set: nibble i written by the rectangle
		logic              last;
	} req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage : npc_pkg
`default_nettype wire

@@ src/npc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// npc_front - pixel front end
// Tracks rectangle, row and word position, packs pixels four to a word and
// issues a column write request whenever a word is flushed.
// ----------------------------------------------------------------------------
module npc_front
	import npc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              in_fire,
	input  wire logic [NIB_W-1:0]  pixel_value,
	input  wire logic              pixel_last,
	output logic                   push,
	output req_t                   push_req
);

	logic               active_q;
	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;
	logic [1:0]         piw_q;
	logic [WIDTH_W-1:0] pir_q;
	logic [WORD_W-1:0]  asm_q;
	logic [NIBS-1:0]    cov_q;

	logic [WIDTH_W-1:0] width_eff;
	logic               row_start;
	logic [POS_W-1:0]   col_c;
	logic [POS_W-1:0]   row_c;
	logic [1:0]         piw_c;
	logic [WIDTH_W-1:0] pir_c;
	logic [WIDTH_W-1:0] pir_n;
	logic [WORD_W-1:0]  asm_c;
	logic [WORD_W-1:0]  asm_n;
	logic [NIBS-1:0]    cov_c;
	logic [NIBS-1:0]    cov_n;
	logic [NIB_W-1:0]   pix_c;
	logic               row_end;
	logic               full;
	logic               flush;
	logic [POS_W-1:0]   row_inc;

	// clamp width to 1..256
	always_comb begin
		if (cfg.region_width == '0) begin
			width_eff = WIDTH_W'(1);
		end else if (cfg.region_width > WIDTH_W'(MAX_WIDTH)) begin
			width_eff = WIDTH_W'(MAX_WIDTH);
		end else begin
			width_eff = cfg.region_width;
		end
	end

	// position of this pixel: new rectangle and new row restart counters
	assign row_start = !active_q || (pir_q == '0);
	assign row_c     = active_q ? row_q : POS_W'(cfg.origin_y);
	assign pir_c     = active_q ? pir_q : '0;
	assign col_c     = row_start ? POS_W'(cfg.origin_x[OX_W-1:2]) : col_q;
	assign piw_c     = row_start ? cfg.origin_x[1:0] : piw_q;
	assign asm_c     = row_start ? '0 : asm_q;
	assign cov_c     = row_start ? '0 : cov_q;

	// pixel expansion and packing, first pixel in the high nibble
	assign pix_c = (cfg.binary_mode && pixel_value != '0) ? {NIB_W{1'b1}} : pixel_value;
	assign asm_n = asm_c | (WORD_W'(pix_c) << {~piw_c, 2'b00});
	assign cov_n = cov_c | (NIBS'(4'b1000) >> piw_c);
	assign pir_n = pir_c + WIDTH_W'(1);

	// flush conditions
	assign row_end = (pir_n >= width_eff) || (pir_n == '0);
	assign full    = (piw_c == 2'd3);
	assign flush   = full || row_end || pixel_last;
	assign row_inc = (row_c == {POS_W{1'b1}}) ? row_c : row_c + POS_W'(1);

	assign push     = in_fire && flush;
	assign push_req = '{col: col_c, row: row_c, word: asm_n, cov: cov_n, last: pixel_last};

	// position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			piw_q    <= '0;
			pir_q    <= '0;
			asm_q    <= '0;
			cov_q    <= '0;
		end else if (in_fire) begin
			active_q <= !pixel_last;
			if (flush) begin
				asm_q <= '0;
				cov_q <= '0;
				piw_q <= '0;
				if (row_end || pixel_last) begin
					pir_q <= '0;
					row_q <= row_inc;
					col_q <= col_c;
				end else begin
					pir_q <= pir_n;
					row_q <= row_c;
					col_q <= col_c + POS_W'(1);
				end
			end else begin
				asm_q <= asm_n;
				cov_q <= cov_n;
				piw_q <= piw_c + 2'd1;
				pir_q <= pir_n;
				row_q <= row_c;
				col_q <= col_c;
			end
		end
	end

endmodule : npc_front
`default_nettype wire

@@ src/npc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// npc_queue - request queue
// Short FIFO of column write requests between the front and back ends.
// ----------------------------------------------------------------------------
module npc_queue
	import npc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire req_t push_req,
	input  wire logic pop,
	output req_t      head,
	output qstat_t    stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	req_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule : npc_queue
`default_nettype wire

@@ src/npc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// npc_back - column write back end
// Reads the shadow word, merges uncovered pixels, writes the shadow RAM and
// presents the column write. Clears the shadow RAM after reset.
// ----------------------------------------------------------------------------
module npc_back
	import npc_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire req_t              q_head,
	input  wire logic              q_empty,
	output logic                   pop,
	output logic                   clr_busy,
	output logic                   column_valid,
	input  wire logic              column_stall,
	output logic [IDX_W-1:0]       column_index,
	output logic [IDX_W-1:0]       row_index,
	output logic [WORD_W-1:0]      column_word,
	output logic                   clipped,
	output logic                   region_done
);

	localparam int CAW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RAW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int ADDR_W = CAW + RAW;
	localparam int RAM_D  = 1 << ADDR_W;

	logic [WORD_W-1:0] shadow_mem [RAM_D];

	logic              clr_q;
	logic [ADDR_W-1:0] clr_cnt_q;

	logic              valid_s1;
	req_t              req_s1;
	logic              inp_s1;
	logic              byp_s1;
	logic [WORD_W-1:0] byp_data_s1;
	logic [WORD_W-1:0] rdata_q;

	logic              inp_head;
	logic [ADDR_W-1:0] addr_head;
	logic [ADDR_W-1:0] addr_s1;
	logic [WORD_W-1:0] old_s1;
	logic [WORD_W-1:0] cov_mask;
	logic [WORD_W-1:0] merged_s1;
	logic              s1_adv;
	logic              hit;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	// panel check and RAM address
	assign inp_head  = ({1'b0, q_head.col} < (POS_W + 1)'(COLUMNS))
	                && ({1'b0, q_head.row} < (POS_W + 1)'(ROWS));
	assign addr_head = {q_head.row[RAW-1:0], q_head.col[CAW-1:0]};
	assign addr_s1   = {req_s1.row[RAW-1:0], req_s1.col[CAW-1:0]};

	// merge: uncovered nibbles keep the shadow pixels, clipped reads as zero
	always_comb begin
		for (int i = 0; i < NIBS; i++) begin
			cov_mask[i*NIB_W +: NIB_W] = {NIB_W{req_s1.cov[i]}};
		end
	end
	assign old_s1    = !inp_s1 ? '0 : (byp_s1 ? byp_data_s1 : rdata_q);
	assign merged_s1 = req_s1.word | (old_s1 & ~cov_mask);

	// stage control
	assign s1_adv   = valid_s1 && (!column_valid || !column_stall);
	assign pop      = !q_empty && !clr_q && (!valid_s1 || s1_adv);
	assign hit      = s1_adv && inp_s1 && inp_head && (addr_s1 == addr_head);
	assign clr_busy = clr_q;

	// RAM write port: clearing pass or merged word
	assign wr_en   = clr_q || (s1_adv && inp_s1);
	assign wr_addr = clr_q ? clr_cnt_q : addr_s1;
	assign wr_data = clr_q ? '0 : merged_s1;

	// shadow RAM
	always_ff @(posedge clk) begin
		if (wr_en) begin
			shadow_mem[wr_addr] <= wr_data;
		end
		if (pop) begin
			rdata_q <= shadow_mem[addr_head];
		end
	end

	// stage payload; a write at the same edge as the read is forwarded
	always_ff @(posedge clk) begin
		if (pop) begin
			req_s1      <= q_head;
			inp_s1      <= inp_head;
			byp_s1      <= hit;
			byp_data_s1 <= merged_s1;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			column_index <= req_s1.col[IDX_W-1:0];
			row_index    <= req_s1.row[IDX_W-1:0];
			column_word  <= merged_s1;
			clipped      <= !inp_s1;
			region_done  <= req_s1.last;
		end
	end

	// control: clearing pass and valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= 1'b1;
			clr_cnt_q    <= '0;
			valid_s1     <= 1'b0;
			column_valid <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
				if (clr_cnt_q == {ADDR_W{1'b1}}) begin
					clr_q <= 1'b0;
				end
			end
			valid_s1     <= pop || (valid_s1 && !s1_adv);
			column_valid <= s1_adv || (column_valid && column_stall);
		end
	end

endmodule : npc_back
`default_nettype wire

@@ src/nibble_pixel_column_packer.sv @@
`default_nettype none
// Path: a word-ending pixel passes the request queue, read stage and output register
// to column_valid. Throughput: one pixel and one column write per cycle when not
// stalled; set by the single shadow RAM read port used once per written word, with a
// 4-entry queue. Reset: control clears at once; the shadow RAM then clears one word
// a cycle, 2**(clog2(COLUMNS)+clog2(ROWS)) words (4096 at 64x64), with pixels stalled.
// ----------------------------------------------------------------------------
// nibble_pixel_column_packer - 4bpp column packer with shadow RAM
// Configuration registers, front end, request queue and back end.
// ----------------------------------------------------------------------------
module nibble_pixel_column_packer
	import npc_pkg::*;
#(
	parameter int COLUMNS = COLUMNS_DEF,
	parameter int ROWS    = ROWS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// pixels
	input  wire logic                  pixel_valid,
	output logic                       pixel_stall,
	input  wire logic [NIB_W-1:0]      pixel_value,
	input  wire logic                  pixel_last,
	// column writes
	output logic                       column_valid,
	input  wire logic                  column_stall,
	output logic [IDX_W-1:0]           column_index,
	output logic [IDX_W-1:0]           row_index,
	output logic [WORD_W-1:0]          column_word,
	output logic                       clipped,
	output logic                       region_done
);

	cfg_t   cfg_q;
	logic   in_fire;
	logic   push;
	req_t   push_req;
	logic   pop;
	req_t   q_head;
	qstat_t qstat;
	logic   clr_busy;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= '0;
			cfg_q.origin_y     <= '0;
			cfg_q.region_width <= WIDTH_W'(1);
			cfg_q.binary_mode  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ORIGIN_X:     cfg_q.origin_x     <= cfg_data[OX_W-1:0];
				CFG_ORIGIN_Y:     cfg_q.origin_y     <= cfg_data[OY_W-1:0];
				CFG_REGION_WIDTH: cfg_q.region_width <= cfg_data[WIDTH_W-1:0];
				CFG_BINARY_MODE:  cfg_q.binary_mode  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// pixel handshake
	assign pixel_stall = clr_busy || qstat.full;
	assign in_fire     = pixel_valid && !pixel_stall;

	npc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_fire     (in_fire),
		.pixel_value (pixel_value),
		.pixel_last  (pixel_last),
		.push        (push),
		.push_req    (push_req)
	);

	npc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (q_head),
		.stat     (qstat)
	);

	npc_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_head       (q_head),
		.q_empty      (qstat.empty),
		.pop          (pop),
		.clr_busy     (clr_busy),
		.column_valid (column_valid),
		.column_stall (column_stall),
		.column_index (column_index),
		.row_index    (row_index),
		.column_word  (column_word),
		.clipped      (clipped),
		.region_done  (region_done)
	);

	// queue never written when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !qstat.full)
		else $error("request pushed into full queue");

	// queue never read when empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("request popped from empty queue");

	// nothing in flight while the shadow RAM is being cleared
	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> (qstat.empty && !column_valid))
		else $error("activity during shadow RAM clear");

endmodule : nibble_pixel_column_packer
`default_nettype wire
